>>> sv/mcsw_pkg.sv
`default_nettype none
package mcsw_pkg;
	localparam int CELL_W = 12;
	localparam int DEPTH = 4096;
	localparam int CNT_W = 13;
	localparam int GEO_W = 7;
	localparam int FLAG_W = 7;
	localparam int MAX_SIDE = 64;

	localparam logic [FLAG_W-1:0] F_BUILT = 7'h10;
	localparam logic [FLAG_W-1:0] F_SOLVED = 7'h20;
	localparam logic [FLAG_W-1:0] F_PATH = 7'h40;

	localparam logic [1:0] PH_BUILD = 2'd0;
	localparam logic [1:0] PH_SOLVE = 2'd1;
	localparam logic [1:0] PH_SOLVED = 2'd2;

	localparam logic [1:0] KIND_RESTART = 2'd0;
	localparam logic [1:0] KIND_STEP = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [2:0] ACT_CARVED = 3'd0;
	localparam logic [2:0] ACT_BUILD_DONE = 3'd1;
	localparam logic [2:0] ACT_ADVANCED = 3'd2;
	localparam logic [2:0] ACT_BACKTRACK = 3'd3;
	localparam logic [2:0] ACT_GOAL = 3'd4;
	localparam logic [2:0] ACT_IDLE = 3'd5;
	localparam logic [2:0] ACT_READ = 3'd6;
	localparam logic [2:0] ACT_RESTART = 3'd7;

	typedef struct packed {
		logic start;
		logic [CELL_W-1:0] dividend;
		logic [GEO_W-1:0] divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic [GEO_W-1:0] rem;
	} rem_rsp_t;

	// direction as flag bit index: 0 N, 1 E, 2 S, 3 W
	function automatic logic [1:0] dir_of(input logic solving, input logic [1:0] k);
		logic [1:0] d;
		case (k)
			2'd0: d = solving ? 2'd2 : 2'd0;
			2'd1: d = solving ? 2'd1 : 2'd2;
			2'd2: d = solving ? 2'd0 : 2'd1;
			default: d = 2'd3;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] mod_small(input logic [7:0] v, input logic [2:0] n);
		logic [3:0] s;
		logic [2:0] r;
		logic [1:0] res;
		s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
		r = 3'(s[1:0]) + 3'(s[3:2]);
		if (r >= 3'd3) r = r - 3'd3;
		if (r >= 3'd3) r = r - 3'd3;
		case (n)
			3'd2: res = {1'b0, v[0]};
			3'd3: res = r[1:0];
			3'd4: res = v[1:0];
			default: res = 2'd0;
		endcase
		return res;
	endfunction
endpackage
`default_nettype wire

>>> sv/mcsw_rem.sv
`default_nettype none
module mcsw_rem (
	input wire logic clk,
	input wire logic arst_n,
	input wire mcsw_pkg::rem_req_t req,
	output mcsw_pkg::rem_rsp_t rsp
);
	logic busy_q, done_q;
	logic [3:0] step_q;
	logic [mcsw_pkg::CELL_W-1:0] dvd_q;
	logic [mcsw_pkg::GEO_W-1:0] rem_q, dsr_q, nrem;
	logic [mcsw_pkg::GEO_W:0] t;

	always_comb begin
		t = {rem_q, dvd_q[mcsw_pkg::CELL_W-1]};
		if (t >= {1'b0, dsr_q}) nrem = mcsw_pkg::GEO_W'(t - {1'b0, dsr_q});
		else nrem = t[mcsw_pkg::GEO_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 4'd1;
				if (step_q == 4'(mcsw_pkg::CELL_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= nrem;
			dvd_q <= dvd_q << 1;
		end
	end

	assign rsp = '{done: done_q, rem: rem_q};
endmodule
`default_nettype wire

>>> sv/maze_carve_and_solve_walker.sv
// channel  | dir | handshake               | payload
// s_axis   | in  | tvalid/tready           | tuser kind, tdata random_value, read_cell
// m_axis   | out | tvalid/tready           | tuser action, tdata phase, cell_index, cell_flags
// apb      | in  | psel/penable/pwrite     | reg 0 grid_width @0, reg 1 grid_height @4
// Each item gives one result: read, restart after the clear, or an idle result for an unused kind.
// Solve step: each stack top takes a remainder pass in the shared unit; at the goal that ends
// the step, otherwise every direction is checked and each open neighbor is probed.
// Build step: examines stack tops until one can carve, or finishes the build when none is left.
// Reset and restart run a clearing pass over all 4096 entries of the mark memory.
// A result waits in the output register while the next item is taken; a later result
// holds the block in its output state until that register frees.
`default_nettype none
module maze_carve_and_solve_walker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [23:0] s_axis_tdata, // random_value[7:0], read_cell[19:8]
	input wire logic [1:0] s_axis_tuser, // kind[1:0]
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // phase[1:0], cell_index[13:2], cell_flags[20:14]
	output logic [2:0] m_axis_tuser, // action[2:0]
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int CW = mcsw_pkg::CELL_W;
	localparam int NW = mcsw_pkg::CNT_W;
	localparam int GW = mcsw_pkg::GEO_W;
	localparam int FW = mcsw_pkg::FLAG_W;

	typedef enum logic [14:0] {
		ST_IDLE = 15'h0001, ST_CLR = 15'h0002, ST_TOP = 15'h0004, ST_TOPW = 15'h0008,
		ST_DIV = 15'h0010, ST_PRB = 15'h0020, ST_PCHK = 15'h0040, ST_BSEL = 15'h0080,
		ST_CRD = 15'h0100, ST_CWR = 15'h0200, ST_BDRD = 15'h0400, ST_BDWR = 15'h0800,
		ST_RDW = 15'h1000, ST_BACK = 15'h2000, ST_OUT = 15'h4000
	} state_t;

	state_t state_q, state_d;
	logic [GW-1:0] gw_q, gh_q, eff_w, eff_h;
	logic [NW-1:0] cells, count_q, count_d;
	logic [CW-1:0] clr_q, clr_d, cur_q, cur_d, rd_q, rd_d, nsel_q, nsel_d;
	logic [1:0] phase_q, phase_d, kind_q, kind_d, k_q, k_d, dsel_q, dsel_d;
	logic [7:0] rnd_q, rnd_d;
	logic rst_pend_q, rst_pend_d;
	logic [FW-1:0] curm_q, curm_d;
	logic [3:0] nb_ok_q, nb_ok_d, cmask_q, cmask_d;
	logic [CW-1:0] nb_q [4];
	logic [CW-1:0] nb_d [4];
	logic [2:0] res_act_q, res_act_d;
	logic [CW-1:0] res_cell_q, res_cell_d;
	logic [FW-1:0] res_flags_q, res_flags_d;
	logic out_valid_q;
	logic [1:0] out_phase_q;
	logic [2:0] out_act_q;
	logic [CW-1:0] out_cell_q;
	logic [FW-1:0] out_flags_q;
	logic out_load;

	logic [FW-1:0] marks [mcsw_pkg::DEPTH];
	logic [CW-1:0] stack [mcsw_pkg::DEPTH];
	logic [CW-1:0] m_addr, s_addr, s_wdata;
	logic [FW-1:0] m_wdata, mrd_q;
	logic m_we, s_we;
	logic [CW-1:0] srd_q;

	mcsw_pkg::rem_req_t rreq;
	mcsw_pkg::rem_rsp_t rrsp;

	logic accept, solving;
	logic [1:0] d, selk, pick;
	logic [2:0] cnt, seen;
	logic [NW-1:0] sum_s;
	logic inr;

	mcsw_rem u_rem (.clk(clk), .arst_n(arst_n), .req(rreq), .rsp(rrsp));

	assign pready = 1'b1;
	assign prdata = {25'd0, paddr[2] ? gh_q : gw_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 7'd40;
			gh_q <= 7'd20;
		end else if (psel && penable && pwrite) begin
			if (paddr[2]) gh_q <= pwdata[GW-1:0];
			else gw_q <= pwdata[GW-1:0];
		end
	end

	always_comb begin
		eff_w = (gw_q == '0) ? GW'(1) : (gw_q > GW'(mcsw_pkg::MAX_SIDE)) ?
			GW'(mcsw_pkg::MAX_SIDE) : gw_q;
		eff_h = (gh_q == '0) ? GW'(1) : (gh_q > GW'(mcsw_pkg::MAX_SIDE)) ?
			GW'(mcsw_pkg::MAX_SIDE) : gh_q;
		cells = NW'(eff_w * eff_h);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);
	assign solving = (phase_q == mcsw_pkg::PH_SOLVE);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		clr_d = clr_q;
		cur_d = cur_q;
		rd_d = rd_q;
		nsel_d = nsel_q;
		phase_d = phase_q;
		kind_d = kind_q;
		k_d = k_q;
		dsel_d = dsel_q;
		rnd_d = rnd_q;
		rst_pend_d = rst_pend_q;
		curm_d = curm_q;
		nb_ok_d = nb_ok_q;
		cmask_d = cmask_q;
		nb_d = nb_q;
		res_act_d = res_act_q;
		res_cell_d = res_cell_q;
		res_flags_d = res_flags_q;
		m_addr = cur_q;
		m_we = 1'b0;
		m_wdata = '0;
		s_addr = CW'(count_q - NW'(1));
		s_we = 1'b0;
		s_wdata = '0;
		rreq.start = 1'b0;
		rreq.dividend = srd_q;
		rreq.divisor = eff_w;
		d = mcsw_pkg::dir_of(solving, k_q);
		cnt = 3'($countones(cmask_q));
		pick = mcsw_pkg::mod_small(rnd_q, cnt);
		seen = '0;
		selk = '0;
		for (int j = 0; j < 4; j++) begin
			if (cmask_q[j]) begin
				if (seen == {1'b0, pick}) selk = 2'(j);
				seen = seen + 3'd1;
			end
		end
		inr = {1'b0, cur_q} < cells;
		sum_s = {1'b0, cur_q} + NW'(eff_w);

		unique case (state_q)
			ST_IDLE: begin
				m_addr = s_axis_tdata[19:8];
				if (accept) begin
					kind_d = s_axis_tuser;
					rnd_d = s_axis_tdata[7:0];
					rd_d = s_axis_tdata[19:8];
					res_act_d = mcsw_pkg::ACT_IDLE;
					res_cell_d = '0;
					res_flags_d = '0;
					state_d = ST_OUT;
					if (s_axis_tuser == mcsw_pkg::KIND_RESTART) begin
						rst_pend_d = 1'b1;
						clr_d = '0;
						state_d = ST_CLR;
					end else if (s_axis_tuser == mcsw_pkg::KIND_READ) begin
						state_d = ST_RDW;
					end else if (s_axis_tuser == mcsw_pkg::KIND_STEP) begin
						if (phase_q == mcsw_pkg::PH_BUILD)
							state_d = (count_q == '0) ? ST_BDRD : ST_TOP;
						else if (solving && count_q != '0)
							state_d = ST_TOP;
					end
				end
			end
			ST_CLR: begin
				m_addr = clr_q;
				m_we = 1'b1;
				m_wdata = (clr_q == '0) ? mcsw_pkg::F_BUILT : '0;
				s_addr = '0;
				s_we = (clr_q == '0);
				count_d = NW'(1);
				phase_d = mcsw_pkg::PH_BUILD;
				clr_d = clr_q + CW'(1);
				if (&clr_q) begin
					rst_pend_d = 1'b0;
					state_d = ST_IDLE;
					if (rst_pend_q) begin
						res_act_d = mcsw_pkg::ACT_RESTART;
						res_cell_d = '0;
						res_flags_d = mcsw_pkg::F_BUILT;
						state_d = ST_OUT;
					end
				end
			end
			ST_TOP: state_d = ST_TOPW;
			ST_TOPW: begin
				cur_d = srd_q;
				rreq.start = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (rrsp.done) begin
					curm_d = mrd_q;
					nb_ok_d[0] = inr && ({1'b0, cur_q} >= NW'(eff_w));
					nb_d[0] = cur_q - CW'(eff_w);
					nb_ok_d[1] = inr && (rrsp.rem != eff_w - GW'(1));
					nb_d[1] = cur_q + CW'(1);
					nb_ok_d[2] = inr && (sum_s < cells);
					nb_d[2] = sum_s[CW-1:0];
					nb_ok_d[3] = inr && (rrsp.rem != '0);
					nb_d[3] = cur_q - CW'(1);
					k_d = '0;
					cmask_d = '0;
					if (solving && ({1'b0, cur_q} == cells - NW'(1))) begin
						phase_d = mcsw_pkg::PH_SOLVED;
						res_act_d = mcsw_pkg::ACT_GOAL;
						res_cell_d = cur_q;
						res_flags_d = mrd_q;
						state_d = ST_OUT;
					end else begin
						state_d = ST_PRB;
					end
				end
			end
			ST_PRB: begin
				if (nb_ok_q[d] && (!solving || curm_q[d])) begin
					m_addr = nb_q[d];
					state_d = ST_PCHK;
				end else if (k_q == 2'd3) begin
					state_d = solving ? ST_BACK : ST_BSEL;
				end else begin
					k_d = k_q + 2'd1;
				end
			end
			ST_PCHK: begin
				m_addr = nb_q[d];
				if (solving && !mrd_q[5]) begin
					m_we = 1'b1;
					m_wdata = mrd_q | mcsw_pkg::F_SOLVED | mcsw_pkg::F_PATH;
					s_addr = count_q[CW-1:0];
					s_wdata = nb_q[d];
					if (count_q < NW'(mcsw_pkg::DEPTH)) begin
						s_we = 1'b1;
						count_d = count_q + NW'(1);
					end
					res_act_d = mcsw_pkg::ACT_ADVANCED;
					res_cell_d = nb_q[d];
					res_flags_d = m_wdata;
					state_d = ST_OUT;
				end else begin
					if (!solving && !mrd_q[4]) cmask_d[k_q] = 1'b1;
					if (k_q == 2'd3) state_d = solving ? ST_BACK : ST_BSEL;
					else begin
						k_d = k_q + 2'd1;
						state_d = ST_PRB;
					end
				end
			end
			ST_BSEL: begin
				if (cnt == '0) begin
					count_d = count_q - NW'(1);
					state_d = (count_q == NW'(1)) ? ST_BDRD : ST_TOP;
				end else begin
					dsel_d = mcsw_pkg::dir_of(1'b0, selk);
					nsel_d = nb_q[dsel_d];
					m_we = 1'b1;
					m_wdata = curm_q | FW'(1 << dsel_d);
					state_d = ST_CRD;
				end
			end
			ST_CRD: begin
				m_addr = nsel_q;
				state_d = ST_CWR;
			end
			ST_CWR: begin
				m_addr = nsel_q;
				m_we = 1'b1;
				m_wdata = mrd_q | FW'(1 << (dsel_q ^ 2'd2)) | mcsw_pkg::F_BUILT;
				s_addr = count_q[CW-1:0];
				s_wdata = nsel_q;
				if (count_q < NW'(mcsw_pkg::DEPTH)) begin
					s_we = 1'b1;
					count_d = count_q + NW'(1);
				end
				res_act_d = mcsw_pkg::ACT_CARVED;
				res_cell_d = nsel_q;
				res_flags_d = m_wdata;
				state_d = ST_OUT;
			end
			ST_BDRD: begin
				m_addr = '0;
				state_d = ST_BDWR;
			end
			ST_BDWR: begin
				m_addr = '0;
				m_we = 1'b1;
				m_wdata = mrd_q | mcsw_pkg::F_SOLVED | mcsw_pkg::F_PATH;
				s_addr = '0;
				s_we = 1'b1;
				count_d = NW'(1);
				phase_d = mcsw_pkg::PH_SOLVE;
				res_act_d = mcsw_pkg::ACT_BUILD_DONE;
				res_cell_d = '0;
				res_flags_d = m_wdata;
				state_d = ST_OUT;
			end
			ST_BACK: begin
				m_we = 1'b1;
				m_wdata = curm_q & ~mcsw_pkg::F_PATH;
				count_d = count_q - NW'(1);
				res_act_d = mcsw_pkg::ACT_BACKTRACK;
				res_cell_d = cur_q;
				res_flags_d = m_wdata;
				state_d = ST_OUT;
			end
			ST_RDW: begin
				res_act_d = mcsw_pkg::ACT_READ;
				res_cell_d = rd_q;
				res_flags_d = ({1'b0, rd_q} < cells) ? mrd_q : '0;
				state_d = ST_OUT;
			end
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (m_we) marks[m_addr] <= m_wdata;
		mrd_q <= marks[m_addr];
	end

	always_ff @(posedge clk) begin
		if (s_we) stack[s_addr] <= s_wdata;
		srd_q <= stack[s_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q <= '0;
			rst_pend_q <= 1'b0;
			count_q <= NW'(1);
			phase_q <= mcsw_pkg::PH_BUILD;
			k_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			rst_pend_q <= rst_pend_d;
			count_q <= count_d;
			phase_q <= phase_d;
			k_q <= k_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		rd_q <= rd_d;
		nsel_q <= nsel_d;
		kind_q <= kind_d;
		dsel_q <= dsel_d;
		rnd_q <= rnd_d;
		curm_q <= curm_d;
		nb_ok_q <= nb_ok_d;
		cmask_q <= cmask_d;
		nb_q <= nb_d;
		res_act_q <= res_act_d;
		res_cell_q <= res_cell_d;
		res_flags_q <= res_flags_d;
		if (out_load) begin
			out_phase_q <= phase_q;
			out_act_q <= res_act_q;
			out_cell_q <= res_cell_q;
			out_flags_q <= res_flags_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = out_act_q;
	assign m_axis_tdata = {3'd0, out_flags_q, out_cell_q, out_phase_q};
endmodule
`default_nettype wire

>>> sv/mcsw_chk.sv
`default_nettype none
module mcsw_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [23:0] m_axis_tdata,
	input wire logic [2:0] m_axis_tuser
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken while busy");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == mcsw_pkg::ACT_RESTART |->
			m_axis_tdata[13:0] == 14'd0 && m_axis_tdata[20:14] == mcsw_pkg::F_BUILT)
		else $error("restart result malformed");

	a_goal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == mcsw_pkg::ACT_GOAL |->
			m_axis_tdata[1:0] == mcsw_pkg::PH_SOLVED)
		else $error("goal without solved phase");
endmodule

bind maze_carve_and_solve_walker mcsw_chk u_chk (.*);
`default_nettype wire
